/* rtl/core/pcg_pkg.sv */
// Package for the polyhedral cell geometry block: face count limits, status codes, types.
// No dependencies.
package pcg_pkg;

    localparam int MaxFacesDefault = 8;
    localparam int MinFaces        = 4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_LOAD   = 7'b0000001,
        ST_DIV    = 7'b0000010,
        ST_FETCH  = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_FACE   = 7'b0010000,
        ST_SEND   = 7'b0100000,
        ST_VOL    = 7'b1000000
    } state_t;

endpackage

/* rtl/core/pcg_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pcg_ram #(
    parameter int Width = 32,
    parameter int Depth = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

/* rtl/core/polyhedral_cell_geometry.sv */
// Top level of the polyhedral cell geometry block.
// Uses pcg_pkg and pcg_ram (one RAM holds all stored face fields).
//
// Faces load one per cycle while the block is loading. A cell with too few or
// too many faces gives its single error result on the cycle after its last
// face. Otherwise, after the last face the block computes the cell center with
// a shared restoring divider, one axis after another. Then for each face it
// fetches the stored face from RAM and runs one shared 34x19 multiplier three
// times for the dot product and four times for distance*area (16-bit
// partials), then transfers the output. After the last face it divides the
// volume by three, done as a reciprocal multiply from shifted adds.
// Input is not ready from the last face until the last result is taken.
module polyhedral_cell_geometry
    import pcg_pkg::*;
#(
    parameter int MAX_FACES = MaxFacesDefault
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // index[31:0], cx[63:32], cy[95:64], cz[127:96], nx[145:128],
    // ny[163:146], nz[181:164], area[213:182], zero fill to 216
    input  logic [215:0]  s_tdata,
    input  logic          s_tlast,          // last_face
    output logic          m_tvalid,
    input  logic          m_tready,
    // index[31:0], distance[63:32], cx[95:64], cy[127:96], cz[159:128],
    // volume[207:160]
    output logic [207:0]  m_tdata,
    output logic [2:0]    m_tuser,          // points_outward[0], status[2:1]
    output logic          m_tlast           // last_result
);
    localparam int AW = $clog2(MAX_FACES);
    localparam int CW = $clog2(MAX_FACES + 1);
    localparam int SW = 32 + CW;
    localparam int RW = 214;
    localparam int VW = 48 + CW;
    localparam int PW = VW + 63;

    state_t state_reg;
    logic [CW-1:0] count_reg, idx_reg;
    logic          many_reg;
    logic signed [SW-1:0] sum_reg [3];
    logic signed [31:0]   cen_reg [3];

    // Shared restoring divider
    logic [55:0] dnum_reg;      // partial remainder register
    logic [55:0] ddiv_reg;
    logic [55:0] quo_reg;
    logic [5:0]  dstep_reg;
    logic [1:0]  axis_reg;
    logic        dneg_reg;

    // Shared multiplier
    logic signed [33:0] ma_reg;
    logic signed [18:0] mb_reg;
    logic signed [52:0] mp;
    logic signed [54:0] dot_reg;
    logic [2:0]         mstep_reg;
    logic [63:0]        prod_reg;
    logic [VW-1:0]      vacc_reg;
    logic [31:0]        dist_reg;

    // Volume divide by three
    logic [PW-1:0]      vprod_reg;
    logic [PW-1:0]      vsum;

    logic [RW-1:0] rd;
    logic          we;
    logic [AW-1:0] raddr;

    assign we = (state_reg == ST_LOAD) && s_tvalid && s_tready
                && (count_reg < CW'(MAX_FACES));
    assign raddr = idx_reg[AW-1:0];

    pcg_ram #(.Width(RW), .Depth(MAX_FACES)) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(count_reg[AW-1:0]),
        .wdata(s_tdata[RW-1:0]),
        .raddr(raddr),
        .rdata(rd)
    );

    assign s_tready = (state_reg == ST_LOAD);
    assign mp = ma_reg * mb_reg;

    // Outputs
    logic        out_pos_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;
    logic [31:0] out_index_reg;
    logic [47:0] out_vol_reg;
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_status_reg, out_pos_reg};
    assign m_tdata  = {out_vol_reg,
                       out_last_reg ? cen_reg[2] : 32'd0,
                       out_last_reg ? cen_reg[1] : 32'd0,
                       out_last_reg ? cen_reg[0] : 32'd0,
                       dist_reg, out_index_reg};

    logic signed [SW-1:0] cur_sum;
    logic [SW-1:0]        cur_mag;
    logic [56:0]          dtrial;
    logic signed [32:0]   diff;
    logic [54:0]          dmag;
    logic [38:0]          dround;
    assign cur_sum = sum_reg[axis_reg];
    assign cur_mag = cur_sum[SW-1] ? SW'(-cur_sum) : cur_sum;
    assign dtrial  = {dnum_reg[55:0], quo_reg[55]} ;
    assign dmag    = dot_reg[54] ? 55'(-dot_reg) : 55'(dot_reg);
    assign dround  = 39'((dmag + 55'h8000) >> 16);
    // (vacc + 1) * ((2^64 + 2) / 3); the quotient sits from bit 64 up
    assign vsum    = vprod_reg + PW'(vacc_reg) + PW'(1);

    always_comb begin
        unique case (mstep_reg)
            3'd0: diff = 33'(signed'(rd[63:32]))  - 33'(cen_reg[0]);
            3'd1: diff = 33'(signed'(rd[95:64]))  - 33'(cen_reg[1]);
            default: diff = 33'(signed'(rd[127:96])) - 33'(cen_reg[2]);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            many_reg  <= 1'b0;
            for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
            idx_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_tvalid) begin
                        if (we) begin
                            count_reg  <= count_reg + 1'b1;
                            sum_reg[0] <= sum_reg[0] + SW'(signed'(s_tdata[63:32]));
                            sum_reg[1] <= sum_reg[1] + SW'(signed'(s_tdata[95:64]));
                            sum_reg[2] <= sum_reg[2] + SW'(signed'(s_tdata[127:96]));
                        end else begin
                            many_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            axis_reg  <= 2'd0;
                            dstep_reg <= 6'd0;
                            vacc_reg  <= '0;
                            idx_reg   <= '0;
                        end
                    end
                    if (s_tvalid && s_tlast) begin
                        if (many_reg || !we) begin
                            out_status_reg <= STATUS_TOO_MANY;
                            state_reg <= ST_SEND;
                        end else if (count_reg + 1'b1 < CW'(MinFaces)) begin
                            out_status_reg <= STATUS_TOO_FEW;
                            state_reg <= ST_SEND;
                        end else begin
                            out_status_reg <= STATUS_OK;
                            state_reg <= ST_DIV;
                        end
                        out_pos_reg   <= 1'b0;
                        dist_reg      <= '0;
                        out_index_reg <= '0;
                        out_vol_reg   <= '0;
                        out_last_reg  <= 1'b1;
                        for (int i = 0; i < 3; i++) cen_reg[i] <= '0;
                    end
                end
                ST_DIV: begin
                    // center axis: (|s| + n/2) / n, restoring, one bit a cycle
                    if (dstep_reg == 6'd0) begin
                        quo_reg   <= 56'(cur_mag + SW'(count_reg >> 1)) << (56 - SW);
                        dnum_reg  <= '0;
                        ddiv_reg  <= 56'(count_reg);
                        dneg_reg  <= cur_sum[SW-1];
                        dstep_reg <= 6'd1;
                    end else if (dstep_reg <= 6'(SW)) begin
                        if (dtrial >= 57'(ddiv_reg)) begin
                            dnum_reg <= 56'(dtrial - 57'(ddiv_reg));
                            quo_reg  <= {quo_reg[54:0], 1'b1};
                        end else begin
                            dnum_reg <= dtrial[55:0];
                            quo_reg  <= {quo_reg[54:0], 1'b0};
                        end
                        dstep_reg <= dstep_reg + 1'b1;
                    end else begin
                        cen_reg[axis_reg] <= dneg_reg ? 32'(-quo_reg[31:0]) : quo_reg[31:0];
                        dstep_reg <= 6'd0;
                        if (axis_reg == 2'd2) state_reg <= ST_FETCH;
                        else axis_reg <= axis_reg + 1'b1;
                    end
                end
                ST_FETCH: begin
                    mstep_reg <= 3'd0;
                    dot_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // three dot terms, then round and saturate the distance, set the sign, clear the product
                    mstep_reg <= mstep_reg + 1'b1;
                    unique case (mstep_reg)
                        3'd0: begin ma_reg <= 34'(diff); mb_reg <= 19'(signed'(rd[145:128])); end
                        3'd1: begin ma_reg <= 34'(diff); mb_reg <= 19'(signed'(rd[163:146]));
                                    dot_reg <= dot_reg + 55'(mp); end
                        3'd2: begin ma_reg <= 34'(diff); mb_reg <= 19'(signed'(rd[181:164]));
                                    dot_reg <= dot_reg + 55'(mp); end
                        3'd3: dot_reg <= dot_reg + 55'(mp);
                        3'd4: begin
                            dist_reg <= (dround > 39'hFFFFFFFF) ? 32'hFFFFFFFF : dround[31:0];
                            out_pos_reg <= !dot_reg[54];
                        end
                        3'd5: begin ma_reg <= {18'd0, dist_reg[15:0]};
                                    mb_reg <= '0; prod_reg <= '0; end
                        default: ;
                    endcase
                    if (mstep_reg == 3'd5) state_reg <= ST_FACE;
                end
                ST_FACE: begin
                    // 32x32 product as four 16x16 partials on the shared unit, then add it to the volume sum
                    mstep_reg <= mstep_reg + 1'b1;
                    unique case (mstep_reg)
                        3'd6: begin ma_reg <= {18'd0, dist_reg[15:0]};
                                    mb_reg <= {3'd0, rd[197:182]}; end
                        3'd7: begin prod_reg <= 64'(mp[31:0]);
                                    ma_reg <= {18'd0, dist_reg[31:16]}; end
                        3'd0: begin prod_reg <= prod_reg + (64'(mp[31:0]) << 16);
                                    ma_reg <= {18'd0, dist_reg[15:0]};
                                    mb_reg <= {3'd0, rd[213:198]}; end
                        3'd1: begin prod_reg <= prod_reg + (64'(mp[31:0]) << 16);
                                    ma_reg <= {18'd0, dist_reg[31:16]}; end
                        3'd2: prod_reg <= prod_reg + (64'(mp[31:0]) << 32);
                        default: begin
                            vacc_reg <= vacc_reg + VW'(prod_reg >> 16) + VW'(prod_reg[15]);
                            out_index_reg  <= rd[31:0];
                            out_status_reg <= STATUS_OK;
                            out_last_reg   <= 1'b0;
                            if (idx_reg + 1'b1 == count_reg) begin
                                dstep_reg <= 6'd0;
                                state_reg <= ST_VOL;
                            end else begin
                                state_reg <= ST_SEND;
                            end
                        end
                    endcase
                end
                ST_VOL: begin
                    // (vacc + 1) / 3: multiply by 0x5555...5555 through five
                    // doubling shifted adds, add one more x, keep bits 64 up
                    dstep_reg <= dstep_reg + 1'b1;
                    case (dstep_reg)
                        6'd0: vprod_reg <= PW'(vacc_reg) + PW'(1);
                        6'd1: vprod_reg <= vprod_reg + (vprod_reg << 2);
                        6'd2: vprod_reg <= vprod_reg + (vprod_reg << 4);
                        6'd3: vprod_reg <= vprod_reg + (vprod_reg << 8);
                        6'd4: vprod_reg <= vprod_reg + (vprod_reg << 16);
                        6'd5: vprod_reg <= vprod_reg + (vprod_reg << 32);
                        default: begin
                            out_vol_reg  <= (vsum[PW-1:112] != '0) ? 48'hFFFFFFFFFFFF
                                                                   : vsum[111:64];
                            out_last_reg <= 1'b1;
                            state_reg    <= ST_SEND;
                        end
                    endcase
                end
                ST_SEND: begin
                    if (m_tready) begin
                        if (out_last_reg) begin
                            state_reg <= ST_LOAD;
                            count_reg <= '0;
                            many_reg  <= 1'b0;
                            for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_tready) else $error("ready while busy");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_FACES)) else $error("face count overflow");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:1] != STATUS_OK) |-> m_tlast)
        else $error("error result not last");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0))
        else $error("cell not cleared");
`endif
endmodule
